// ===== hw/rtl/stat_pkg.sv =====
// Package for the section table address translator: codes, payload and entry types.
`timescale 1ns / 1ps
`default_nettype none

package stat_pkg;

    // Default table depth
    localparam int MAX_SECTIONS_DEF = 16;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_VIRT_TO_FILE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RANGE_END   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RANGE_START = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIRST_START = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIRST_END   = 3'd5;

    // Answer on a miss
    localparam logic [ADDR_W-1:0] ANSWER_MISS = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] entry_index;
        logic [ADDR_W-1:0] section_virtual_address;
        logic [ADDR_W-1:0] section_virtual_size;
        logic [ADDR_W-1:0] section_file_offset;
        logic [ADDR_W-1:0] section_file_size;
        logic [ADDR_W-1:0] query_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] answer;
        logic              found;
    } t_out_item;

    // One stored section
    typedef struct packed {
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] vsize;
        logic [ADDR_W-1:0] foff;
        logic [ADDR_W-1:0] fsize;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // request taken this cycle
        logic rd_en;       // read the table
        logic latch_hit;   // keep the matching entry's answer
        logic latch_miss;  // keep the miss answer
        logic load_out;    // move the result into the output register
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic hit;         // entry on the read port matches
        logic out_free;    // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/stat_ram.sv =====
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module stat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic                                        i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stat_ctrl.sv =====
// Controller: request handshake, section count register and table scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

module stat_ctrl #(
    parameter int MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    input  wire logic [stat_pkg::CMD_W-1:0]             i_command,
    output      logic                                   o_in_stall,
    input  wire logic                                   i_cfg_valid,
    output      logic                                   o_cfg_ready,
    input  wire logic [stat_pkg::COUNT_W-1:0]           i_cfg_data,
    input  wire stat_pkg::t_stat                        i_stat,
    output      stat_pkg::t_ctl                         o_ctl,
    output      logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] o_rd_addr
);

    import stat_pkg::*;

    localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CW = ($clog2(MAX_SECTIONS + 1) > COUNT_W) ?
                        $clog2(MAX_SECTIONS + 1) : COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [CW-1:0]        live_n;
    logic                 is_query;
    logic                 issue;

    // Entries searched: count clamped to the table depth
    assign live_n = (CW'(r_count) > CW'(MAX_SECTIONS)) ? CW'(MAX_SECTIONS) : CW'(r_count);

    assign is_query = i_command inside {CMD_VIRT_TO_FILE, CMD_RANGE_END, CMD_RANGE_START,
                                        CMD_FIRST_START, CMD_FIRST_END};

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign issue       = (r_state == S_RUN) && (r_idx < live_n);
    assign o_rd_addr   = r_idx[IW-1:0];

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        n_pend           = r_pend;
        o_ctl            = '0;
        o_ctl.accept     = i_in_valid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                n_idx  = '0;
                n_pend = 1'b0;
                if (i_in_valid && is_query) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_pend && i_stat.hit) begin
                    o_ctl.latch_hit = 1'b1;
                    n_state         = S_DONE;
                end else if (!issue && !r_pend) begin
                    o_ctl.latch_miss = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.rd_en = issue;
                    n_pend      = issue;
                    if (issue) begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, scan index and count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stat_dp.sv =====
// Datapath: section table, match logic, result latch and output register.
`timescale 1ns / 1ps
`default_nettype none

module stat_dp #(
    parameter int MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire stat_pkg::t_in_item                     i_in,
    input  wire stat_pkg::t_ctl                         i_ctl,
    input  wire logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] i_rd_addr,
    output      stat_pkg::t_stat                        o_stat,
    output      logic                                   o_out_valid,
    input  wire logic                                   i_out_stall,
    output      stat_pkg::t_out_item                    o_out
);

    import stat_pkg::*;

    localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int EW = $bits(t_entry);

    logic [CMD_W-1:0]  r_cmd;
    logic [ADDR_W-1:0] r_q;
    logic [ADDR_W-1:0] r_ans;
    logic              r_found;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              wr_en;
    t_entry            wr_entry;
    logic [EW-1:0]     rd_data;
    t_entry            ent;
    logic [ADDR_W-1:0] vend, fend;
    logic              hit;
    logic [ADDR_W-1:0] ans;

    // Table write on a load to a present slot
    assign wr_en = i_ctl.accept && (i_in.command == CMD_LOAD) &&
                   (32'(i_in.entry_index) < 32'(MAX_SECTIONS));
    assign wr_entry.va    = i_in.section_virtual_address;
    assign wr_entry.vsize = i_in.section_virtual_size;
    assign wr_entry.foff  = i_in.section_file_offset;
    assign wr_entry.fsize = i_in.section_file_size;

    stat_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SECTIONS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IW'(i_in.entry_index)),
        .i_wr_data (wr_entry),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    assign ent  = t_entry'(rd_data);
    assign vend = ent.va + ent.vsize;
    assign fend = ent.foff + ent.fsize;

    // Match test and answer for the entry on the read port
    always_comb begin
        hit = 1'b0;
        ans = ANSWER_MISS;
        case (r_cmd)
            CMD_VIRT_TO_FILE: begin
                hit = (r_q >= ent.va) && (r_q < vend);
                ans = ent.foff + r_q - ent.va;
            end
            CMD_RANGE_END, CMD_RANGE_START: begin
                hit = (r_q >= ent.foff) && (r_q < fend);
                ans = (r_cmd == CMD_RANGE_END) ? fend : ent.foff;
            end
            CMD_FIRST_START, CMD_FIRST_END: begin
                hit = (ent.fsize != '0);
                ans = (r_cmd == CMD_FIRST_START) ? ent.foff : fend;
            end
            default: begin
                hit = 1'b0;
                ans = ANSWER_MISS;
            end
        endcase
    end

    assign o_stat.hit      = hit;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // Query capture and result latch
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd <= i_in.command;
            r_q   <= i_in.query_address;
        end
        if (i_ctl.latch_hit) begin
            r_ans   <= ans;
            r_found <= 1'b1;
        end else if (i_ctl.latch_miss) begin
            r_ans   <= ANSWER_MISS;
            r_found <= 1'b0;
        end
        if (i_ctl.load_out) begin
            r_out.answer <= r_ans;
            r_out.found  <= r_found;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/section_table_address_translator.sv =====
// Top level of the section table address translator: controller and datapath.
//
//  Channel   Signals                              Direction  Moves
//  input     i_in_valid, o_in_stall, i_in         in         load or query request
//  output    o_out_valid, i_out_stall, o_out      out        answer and found flag
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data in         section count
//
// A load request writes one table slot in the cycle it is taken and gives no result.
// A query searches at most n entries, n being the section count clamped to the
// table depth: the scan reads one entry per cycle through the table's single read
// port and stops at the first match. The next request is taken once the result sits
// in the output register; a stalled output holds the scan in its final state.
// Reset clears the count and control state; table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module section_table_address_translator #(
    parameter int MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_stall,
    input  wire stat_pkg::t_in_item           i_in,
    output      logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    output      stat_pkg::t_out_item          o_out,
    input  wire logic                         i_cfg_valid,
    output      logic                         o_cfg_ready,
    input  wire logic [stat_pkg::COUNT_W-1:0] i_cfg_data
);

    import stat_pkg::*;

    localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    t_ctl          ctl;
    t_stat         stat;
    logic [IW-1:0] rd_addr;

    stat_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in.command),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_ctl       (ctl),
        .o_rd_addr   (rd_addr)
    );

    stat_dp #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ctl       (ctl),
        .i_rd_addr   (rd_addr),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== bench/section_table_address_translator_tb.sv =====
// Self-checking testbench for the section table address translator.
`timescale 1ns / 1ps

module section_table_address_translator_tb;
    import stat_pkg::*;

    localparam int MAX_SECTIONS  = MAX_SECTIONS_DEF;
    localparam int SETTLE_CYCLES = MAX_SECTIONS + 8;
    localparam int PHASE_ITEMS   = 107;
    localparam int REPORT_LIMIT  = 10;

    // Commands the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    typedef enum logic { ROW_CONFIG, ROW_REQUEST } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [COUNT_W-1:0] count;
        t_in_item           req;
        bit                 typed;
        t_out_item          want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    t_in_item           in_req;
    logic               out_valid;
    logic               out_stall;
    t_out_item          out_res;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    // Shadow of the block's table and count, and answers still to come
    t_entry             section_shadow [MAX_SECTIONS];
    logic [COUNT_W-1:0] count_shadow;
    t_out_item          awaited_answers [$];

    t_row directed_rows [$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   mismatch_count;
    int   cfg_plan [15] = '{16, 0, 31, 1, 20, 5, 16, 2, 24, 9, 16, 17, 3, 12, 31};

    section_table_address_translator #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver back-pressure, changed on the falling edge
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t: %s: expected answer %08h found %0b, got answer %08h found %0b",
                     $realtime, what, want.answer, want.found, got.answer, got.found);
        mismatch_count++;
    endtask

    // Compare each result taken with the oldest awaited answer
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (awaited_answers.size() == 0) begin
                report_mismatch("unexpected result", '0, out_res);
            end else begin
                want = awaited_answers.pop_front();
                if (out_res.answer !== want.answer || out_res.found !== want.found)
                    report_mismatch("wrong result", want, out_res);
            end
        end
    end

    // Apply one request to the shadow table; a query queues its answer
    task automatic translate_request(input t_in_item req, input bit typed,
                                     input t_out_item typed_want);
        t_out_item         res;
        t_entry            e;
        logic [ADDR_W-1:0] vend;
        logic [ADDR_W-1:0] fend;
        logic [ADDR_W-1:0] q;
        int unsigned       n;
        bit                hit;
        q = req.query_address;
        if (req.command == CMD_LOAD) begin
            if (req.entry_index < MAX_SECTIONS) begin
                section_shadow[req.entry_index].va    = req.section_virtual_address;
                section_shadow[req.entry_index].vsize = req.section_virtual_size;
                section_shadow[req.entry_index].foff  = req.section_file_offset;
                section_shadow[req.entry_index].fsize = req.section_file_size;
            end
            return;
        end
        if (req.command > CMD_FIRST_END)
            return;
        // Counts above the table depth search the whole table
        n = (count_shadow > MAX_SECTIONS) ? MAX_SECTIONS : count_shadow;
        res.answer = ANSWER_MISS;
        res.found  = 1'b0;
        hit        = 1'b0;
        for (int i = 0; i < n && !hit; i++) begin
            e    = section_shadow[i];
            vend = e.va + e.vsize;
            fend = e.foff + e.fsize;
            case (req.command)
                CMD_VIRT_TO_FILE: begin
                    if (q >= e.va && q < vend) begin
                        res.answer = e.foff + (q - e.va);
                        hit        = 1'b1;
                    end
                end
                CMD_RANGE_END, CMD_RANGE_START: begin
                    if (q >= e.foff && q < fend) begin
                        res.answer = (req.command == CMD_RANGE_END) ? fend : e.foff;
                        hit        = 1'b1;
                    end
                end
                default: begin
                    if (e.fsize != '0) begin
                        res.answer = (req.command == CMD_FIRST_START) ? e.foff : fend;
                        hit        = 1'b1;
                    end
                end
            endcase
        end
        res.found = hit;
        awaited_answers.push_back(typed ? typed_want : res);
    endtask

    // Offer one request, idling first at random; returns at the accepting edge
    task automatic drive_request(input t_in_item req, input bit typed,
                                 input t_out_item typed_want);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_req   = req;
        do @(posedge i_clk); while (in_stall);
        translate_request(req, typed, typed_want);
    endtask

    // Drop valid and hold off until every awaited answer has come
    task automatic wait_for_drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (awaited_answers.size() != 0)
            @(negedge i_clk);
    endtask

    // Count register write, only with the block idle
    task automatic write_count(input logic [COUNT_W-1:0] value);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        count_shadow = value;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Request with random section data shaped towards overlapping ranges
    function automatic t_in_item random_request();
        t_in_item          req;
        t_entry            e;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        int unsigned       n;
        int unsigned       roll;
        req.entry_index   = SLOT_W'($urandom_range(MAX_SECTIONS - 1));
        req.query_address = $urandom;
        case ($urandom_range(3))
            0: begin
                req.section_virtual_address = $urandom & 32'h0000_FFF0;
                req.section_virtual_size    = $urandom_range(32'h800);
                req.section_file_offset     = $urandom & 32'h0000_FFF0;
                req.section_file_size       = $urandom_range(32'h800);
            end
            1: begin
                // no file data
                req.section_virtual_address = $urandom & 32'h0000_FFF0;
                req.section_virtual_size    = $urandom_range(32'h800);
                req.section_file_offset     = $urandom & 32'h0000_FFF0;
                req.section_file_size       = '0;
            end
            2: begin
                // near the top, ranges may wrap
                req.section_virtual_address = 32'hFFFF_F000 | ($urandom & 32'hFFF);
                req.section_virtual_size    = $urandom_range(32'h2000);
                req.section_file_offset     = 32'hFFFF_F000 | ($urandom & 32'hFFF);
                req.section_file_size       = $urandom_range(32'h2000);
            end
            default: begin
                req.section_virtual_address = $urandom;
                req.section_virtual_size    = $urandom;
                req.section_file_offset     = $urandom;
                req.section_file_size       = $urandom;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < 20) begin
            req.command = CMD_LOAD;
        end else if (roll < 25) begin
            req.command = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        end else begin
            req.command = CMD_W'($urandom_range(CMD_VIRT_TO_FILE, CMD_FIRST_END));
            n = (count_shadow > MAX_SECTIONS) ? MAX_SECTIONS : count_shadow;
            e = section_shadow[(n == 0) ? $urandom_range(MAX_SECTIONS - 1)
                                        : $urandom_range(n - 1)];
            base = (req.command == CMD_VIRT_TO_FILE) ? e.va : e.foff;
            span = (req.command == CMD_VIRT_TO_FILE) ? e.vsize : e.fsize;
            case ($urandom_range(5))
                0: req.query_address = base + ((span != '0) ? ($urandom % span) : '0);
                1: req.query_address = base + span - 1;
                2: req.query_address = base + span;
                3: req.query_address = base - 1;
                4: req.query_address = base;
                default: req.query_address = $urandom;
            endcase
        end
        return req;
    endfunction

    // Directed table builders
    task automatic add_config(input logic [COUNT_W-1:0] value);
        t_row row;
        row.kind  = ROW_CONFIG;
        row.count = value;
        row.req   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_load(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] va,
                            input logic [ADDR_W-1:0] vsize, input logic [ADDR_W-1:0] foff,
                            input logic [ADDR_W-1:0] fsize);
        t_row row;
        row.kind                        = ROW_REQUEST;
        row.count                       = '0;
        row.req.command                 = CMD_LOAD;
        row.req.entry_index             = slot;
        row.req.section_virtual_address = va;
        row.req.section_virtual_size    = vsize;
        row.req.section_file_offset     = foff;
        row.req.section_file_size       = fsize;
        row.req.query_address           = $urandom;
        row.typed                       = 1'b0;
        row.want                        = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_query(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] q,
                             input bit typed, input logic [ADDR_W-1:0] answer,
                             input logic found);
        t_row row;
        row.kind                        = ROW_REQUEST;
        row.count                       = '0;
        row.req.command                 = cmd;
        row.req.entry_index             = SLOT_W'($urandom);
        row.req.section_virtual_address = $urandom;
        row.req.section_virtual_size    = $urandom;
        row.req.section_file_offset     = $urandom;
        row.req.section_file_size       = $urandom;
        row.req.query_address           = q;
        row.typed                       = typed;
        row.want.answer                 = answer;
        row.want.found                  = found;
        directed_rows.push_back(row);
    endtask

    // Stimulus
    initial begin
        t_in_item req;
        t_row     row;
        int       sent;
        int       phase;
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_req         = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        count_shadow   = '0;
        mismatch_count = 0;
        send_idle_pct  = 32;
        recv_idle_pct  = 60;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty search after reset: every query misses
        add_config(0);
        add_query(CMD_VIRT_TO_FILE, 32'h0000_0000, 1'b1, ANSWER_MISS, 1'b0);
        add_query(CMD_RANGE_END,    32'hFFFF_FFFF, 1'b1, ANSWER_MISS, 1'b0);
        add_query(CMD_RANGE_START,  32'h0000_0000, 1'b1, ANSWER_MISS, 1'b0);
        add_query(CMD_FIRST_START,  32'hFFFF_FFFF, 1'b1, ANSWER_MISS, 1'b0);
        add_query(CMD_FIRST_END,    32'h0000_0000, 1'b1, ANSWER_MISS, 1'b0);
        // ignored commands
        add_query(CMD_UNUSED_6, 32'h0000_1000, 1'b0, '0, 1'b0);
        add_query(CMD_UNUSED_7, 32'h0000_1000, 1'b0, '0, 1'b0);
        // slot 0 has no file data, slot 1 wraps in both spaces
        add_load(0, 32'h0000_1000, 32'h0000_0100, 32'h0000_0400, 32'h0000_0000);
        add_load(1, 32'hFFFF_FFF0, 32'h0000_0020, 32'hFFFF_FF00, 32'h0000_0200);
        add_load(2, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_2000, 32'h0000_1000);
        add_load(3, 32'hFFFF_FF00, 32'h0000_00FF, 32'hFFFF_0000, 32'h0000_FFFF);
        add_load(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_config(4);
        add_query(CMD_VIRT_TO_FILE, 32'h0000_1000, 1'b1, 32'h0000_0400, 1'b1);
        add_query(CMD_VIRT_TO_FILE, 32'h0000_10FF, 1'b0, '0, 1'b0);
        add_query(CMD_VIRT_TO_FILE, 32'h0000_0000, 1'b0, '0, 1'b0);
        add_query(CMD_VIRT_TO_FILE, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_query(CMD_RANGE_END,    32'h0000_2000, 1'b0, '0, 1'b0);
        add_query(CMD_RANGE_START,  32'h0000_2FFF, 1'b0, '0, 1'b0);
        add_query(CMD_RANGE_START,  32'h0000_3000, 1'b0, '0, 1'b0);
        add_query(CMD_RANGE_END,    32'hFFFF_FFFE, 1'b0, '0, 1'b0);
        add_query(CMD_FIRST_START,  32'h0000_0000, 1'b0, '0, 1'b0);
        add_query(CMD_FIRST_END,    32'h0000_0000, 1'b0, '0, 1'b0);
        // only a section without file data is searched
        add_config(1);
        add_query(CMD_FIRST_START,  32'h0000_0000, 1'b1, ANSWER_MISS, 1'b0);
        add_query(CMD_FIRST_END,    32'h0000_0000, 1'b1, ANSWER_MISS, 1'b0);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CONFIG)
                write_count(row.count);
            else
                drive_request(row.req, row.typed, row.want);
        end

        // Fill every slot so that any count reads written entries only
        for (int s = 0; s < MAX_SECTIONS; s++) begin
            req             = random_request();
            req.command     = CMD_LOAD;
            req.entry_index = SLOT_W'(s);
            drive_request(req, 1'b0, '0);
        end

        // Random phases: three idling modes, five counts each
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 60 : 0;
            recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 32 : 0;
            for (int p = 0; p < 5; p++) begin
                phase = mode * 5 + p;
                write_count(COUNT_W'(cfg_plan[phase]));
                sent = 0;
                while (sent < PHASE_ITEMS) begin
                    // hold off now and then until the block has answered everything
                    if (sent == PHASE_ITEMS / 2 || $urandom_range(199) == 0)
                        wait_for_drain();
                    req = random_request();
                    sent++;
                    drive_request(req, 1'b0, '0);
                end
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
